/* src/tlma_pkg.sv */
`timescale 1ns / 1ps
package tlma_pkg;

    // Input item, one transfer on the s_ channel
    typedef struct packed {
        logic [1:0]         req_type;
        logic [15:0]        char_code;
        logic signed [15:0] glyph_advance;
        logic               glyph_present;
    } tlma_in_t;

    // Result item, one transfer on the m_ channel
    typedef struct packed {
        logic signed [31:0] line_offset;
        logic signed [31:0] line_width;
        logic signed [31:0] total_width;
        logic [23:0]        total_height;
        logic signed [31:0] top_y;
        logic               last;
    } tlma_out_t;

    // Request codes
    localparam logic [1:0] REQ_GLYPH = 2'd0;
    localparam logic [1:0] REQ_CHAR  = 2'd1;
    localparam logic [1:0] REQ_END   = 2'd2;

    localparam logic [15:0]        NEWLINE_CODE    = 16'd10;
    localparam logic [15:0]        SPACE_CODE      = 16'd32;
    localparam logic signed [15:0] MISSING_ADVANCE = 16'sd10;
    localparam logic [23:0]        HEIGHT_MAX      = 24'hFFFFFF;

    // Register file
    localparam int         CFG_ADDR_W    = 5;
    localparam logic [2:0] REG_SCALE_X     = 3'd0;
    localparam logic [2:0] REG_SCALE_Y     = 3'd1;
    localparam logic [2:0] REG_ALIGN_MODE  = 3'd2;
    localparam logic [2:0] REG_LINE_HEIGHT = 3'd3;
    localparam logic [2:0] REG_ANCHOR_Y    = 3'd4;

    localparam logic [15:0] SCALE_RESET = 16'd256;

    typedef enum logic [1:0] {
        HALIGN_LEFT,
        HALIGN_CENTER,
        HALIGN_RIGHT
    } halign_t;

    typedef enum logic [1:0] {
        VALIGN_TOP,
        VALIGN_MIDDLE,
        VALIGN_BOTTOM
    } valign_t;

    typedef struct packed {
        halign_t h;
        valign_t v;
    } align_t;

    // One glyph table entry
    typedef struct packed {
        logic               present;
        logic signed [15:0] advance;
    } glyph_t;

    // Closed line handed from the accumulator to the alignment pipe
    typedef struct packed {
        logic signed [48:0] prod;
        logic [23:0]        height;
        logic               last;
    } close_t;

    // mode mod 3 / mode div 3 as a small table; vertical codes above 2 mean top
    function automatic align_t align_decode(input logic [3:0] mode);
        align_t a;
        a.h = HALIGN_LEFT;
        a.v = VALIGN_TOP;
        case (mode)
            4'd0:  begin a.h = HALIGN_LEFT;   a.v = VALIGN_TOP;    end
            4'd1:  begin a.h = HALIGN_CENTER; a.v = VALIGN_TOP;    end
            4'd2:  begin a.h = HALIGN_RIGHT;  a.v = VALIGN_TOP;    end
            4'd3:  begin a.h = HALIGN_LEFT;   a.v = VALIGN_MIDDLE; end
            4'd4:  begin a.h = HALIGN_CENTER; a.v = VALIGN_MIDDLE; end
            4'd5:  begin a.h = HALIGN_RIGHT;  a.v = VALIGN_MIDDLE; end
            4'd6:  begin a.h = HALIGN_LEFT;   a.v = VALIGN_BOTTOM; end
            4'd7:  begin a.h = HALIGN_CENTER; a.v = VALIGN_BOTTOM; end
            4'd8:  begin a.h = HALIGN_RIGHT;  a.v = VALIGN_BOTTOM; end
            4'd9:  begin a.h = HALIGN_LEFT;   a.v = VALIGN_TOP;    end
            4'd10: begin a.h = HALIGN_CENTER; a.v = VALIGN_TOP;    end
            4'd11: begin a.h = HALIGN_RIGHT;  a.v = VALIGN_TOP;    end
            4'd12: begin a.h = HALIGN_LEFT;   a.v = VALIGN_TOP;    end
            4'd13: begin a.h = HALIGN_CENTER; a.v = VALIGN_TOP;    end
            4'd14: begin a.h = HALIGN_RIGHT;  a.v = VALIGN_TOP;    end
            default: begin a.h = HALIGN_LEFT; a.v = VALIGN_TOP;    end
        endcase
        return a;
    endfunction

    // Clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] r;
        if (v > 50'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -50'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* src/tlma_glyph_ram.sv */
`timescale 1ns / 1ps
module tlma_glyph_ram #(
    parameter int CODE_SPACE = 256,
    localparam int AW = $clog2(CODE_SPACE)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  tlma_pkg::glyph_t  wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output tlma_pkg::glyph_t  rd_data,
    output tlma_pkg::glyph_t  space_glyph,
    output logic              clearing
);
    import tlma_pkg::*;

    glyph_t        mem [CODE_SPACE];
    glyph_t        rd_data_reg;
    glyph_t        space_reg;
    logic          clear_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    // Clearing sweep after reset, one entry a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_busy_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clear_busy_reg) begin
            if (clr_addr_reg == AW'(CODE_SPACE - 1)) begin
                clear_busy_reg <= 1'b0;
            end else begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (clear_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Copy of the space entry for the fallback path
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            space_reg <= '0;
        end else if (wr_en && wr_addr == AW'(SPACE_CODE)) begin
            space_reg <= wr_data;
        end
    end

    assign rd_data     = rd_data_reg;
    assign space_glyph = space_reg;
    assign clearing    = clear_busy_reg;

endmodule

/* src/tlma_line_acc.sv */
`timescale 1ns / 1ps
module tlma_line_acc (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  logic              load_close,
    input  logic              load_last,
    input  logic              load_in_range,
    input  tlma_pkg::glyph_t  rd_glyph,
    input  tlma_pkg::glyph_t  space_glyph,
    input  logic [15:0]       scale_x,
    input  logic [15:0]       line_height,
    input  logic              close_ready,
    output logic              s1_free,
    output logic              close_valid,
    output tlma_pkg::close_t  close
);
    import tlma_pkg::*;

    logic               s1_valid_reg;
    logic               s1_close_reg;
    logic               s1_last_reg;
    logic               s1_in_range_reg;
    logic signed [31:0] line_sum_reg;
    logic signed [31:0] line_sum_next;
    logic [23:0]        height_sum_reg;
    logic [23:0]        height_sum_next;

    logic               s1_go;
    logic signed [15:0] adv;
    logic signed [32:0] sum_wide;
    logic [24:0]        height_wide;
    logic [23:0]        height_sat;

    assign s1_go       = s1_valid_reg && (!s1_close_reg || close_ready);
    assign s1_free     = !s1_valid_reg || s1_go;
    assign close_valid = s1_valid_reg && s1_close_reg;

    // Advance lookup with space and fixed fallbacks
    always_comb begin
        if (s1_in_range_reg && rd_glyph.present) begin
            adv = rd_glyph.advance;
        end else if (space_glyph.present) begin
            adv = space_glyph.advance;
        end else begin
            adv = MISSING_ADVANCE;
        end
        sum_wide    = 33'(line_sum_reg) + 33'(adv);
        height_wide = {1'b0, height_sum_reg} + {9'b0, line_height};
        height_sat  = height_wide[24] ? HEIGHT_MAX : height_wide[23:0];
    end

    // Closed line: scaled width product and height after this line
    always_comb begin
        close.prod   = 49'(line_sum_reg) * $signed({1'b0, scale_x});
        close.height = height_sat;
        close.last   = s1_last_reg;
    end

    // Running sums
    always_comb begin
        line_sum_next   = line_sum_reg;
        height_sum_next = height_sum_reg;
        if (s1_go) begin
            if (s1_close_reg) begin
                line_sum_next   = '0;
                height_sum_next = s1_last_reg ? 24'd0 : height_sat;
            end else begin
                line_sum_next = sat32(50'(sum_wide));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            line_sum_reg   <= '0;
            height_sum_reg <= '0;
        end else begin
            line_sum_reg   <= line_sum_next;
            height_sum_reg <= height_sum_next;
            if (load) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_go) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            s1_close_reg    <= load_close;
            s1_last_reg     <= load_last;
            s1_in_range_reg <= load_in_range;
        end
    end

endmodule

/* src/tlma_align_pipe.sv */
`timescale 1ns / 1ps
module tlma_align_pipe (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                close_valid,
    input  tlma_pkg::close_t    close,
    output logic                close_ready,
    input  logic [15:0]         scale_y,
    input  logic [3:0]          align_mode,
    input  logic signed [23:0]  anchor_y,
    output logic                m_valid,
    input  logic                m_ready,
    output tlma_pkg::tlma_out_t m_data
);
    import tlma_pkg::*;

    align_t             align;

    // Stage 2: product registered
    logic               s2_valid_reg;
    close_t             s2_reg;
    logic               s2_go;

    // Stage 3: width, offset, maximum, vertical span
    logic               s3_valid_reg;
    logic signed [31:0] s3_off_reg;
    logic signed [31:0] s3_width_reg;
    logic signed [31:0] s3_max_reg;
    logic [23:0]        s3_height_reg;
    logic               s3_last_reg;
    logic [39:0]        s3_span_reg;
    logic               s3_go;

    logic signed [31:0] max_width_reg;
    logic signed [31:0] max_width_next;

    tlma_out_t          out_reg;
    logic               out_valid_reg;

    logic signed [31:0] width;
    logic signed [32:0] neg_width;
    logic signed [31:0] offset;
    logic signed [31:0] max_after;
    logic [39:0]        span;
    logic signed [41:0] anchor_wide;
    logic signed [41:0] top_wide;
    logic signed [31:0] top;

    assign align       = align_decode(align_mode);
    assign s3_go       = s3_valid_reg && (!out_valid_reg || m_ready);
    assign s2_go       = s2_valid_reg && (!s3_valid_reg || s3_go);
    assign close_ready = !s2_valid_reg || s2_go;

    // Width, horizontal offset, maximum and vertical span
    always_comb begin
        width     = sat32(50'(s2_reg.prod));
        neg_width = -33'(width);
        case (align.h)
            HALIGN_CENTER: offset = sat32(50'(neg_width >>> 1));
            HALIGN_RIGHT:  offset = sat32(50'(neg_width));
            default:       offset = '0;
        endcase
        max_after = (width > max_width_reg) ? width : max_width_reg;
        span      = 40'(s2_reg.height) * 40'(scale_y);
    end

    always_comb begin
        max_width_next = max_width_reg;
        if (s2_go) begin
            max_width_next = s2_reg.last ? 32'sd0 : max_after;
        end
    end

    // Top y on the last line of a text
    always_comb begin
        anchor_wide = 42'(anchor_y);
        case (align.v)
            VALIGN_MIDDLE: top_wide = anchor_wide - $signed({2'b0, s3_span_reg >> 1});
            VALIGN_BOTTOM: top_wide = anchor_wide - $signed({2'b0, s3_span_reg});
            default:       top_wide = anchor_wide;
        endcase
        top = s3_last_reg ? sat32(50'(top_wide)) : 32'sd0;
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            max_width_reg <= '0;
        end else begin
            max_width_reg <= max_width_next;
            if (close_valid && close_ready) begin
                s2_valid_reg <= 1'b1;
            end else if (s2_go) begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_go) begin
                s3_valid_reg <= 1'b1;
            end else if (s3_go) begin
                s3_valid_reg <= 1'b0;
            end
            if (s3_go) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (close_valid && close_ready) begin
            s2_reg <= close;
        end
        if (s2_go) begin
            s3_off_reg    <= offset;
            s3_width_reg  <= width;
            s3_max_reg    <= max_after;
            s3_height_reg <= s2_reg.height;
            s3_last_reg   <= s2_reg.last;
            s3_span_reg   <= span;
        end
        if (s3_go) begin
            out_reg.line_offset  <= s3_off_reg;
            out_reg.line_width   <= s3_width_reg;
            out_reg.total_width  <= s3_max_reg;
            out_reg.total_height <= s3_height_reg;
            out_reg.top_y        <= top;
            out_reg.last         <= s3_last_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

/* src/text_line_measure_align_top.sv */
`timescale 1ns / 1ps
// Text line measurer for a bitmap font.
// s_ channel (valid/ready): glyph writes fill the advance table, text
// characters add their advance to the current line, a newline or end
// item closes the line. m_ channel (valid/ready): one transfer per closed
// line with its width, alignment offset, running maximum width and height;
// the end item's transfer carries last and the aligned top y.
// APB port: scale_x, scale_y, align_mode, line_height, anchor_y at
// byte addresses 0, 4, 8, 12, 16; write only while the block is idle.
// Throughput: one item per cycle unless a closing item is held up.
// Characters read the table memory at acceptance and are summed in the
// next cycle; a closing item passes table read, width multiply,
// alignment/height multiply and output register before it shows on m_.
// Reset: a clearing sweep marks every glyph absent, with s_ready low
// until it ends; the APB port is live throughout.
// Stall: results queue in the pipeline and output register; s_ready falls
// only when a closing item cannot move on.
module text_line_measure_align_top #(
    parameter int CODE_SPACE = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  tlma_pkg::tlma_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output tlma_pkg::tlma_out_t                 m_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tlma_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import tlma_pkg::*;

    localparam int AW = $clog2(CODE_SPACE);

    logic [15:0]        scale_x_reg;
    logic [15:0]        scale_y_reg;
    logic [3:0]         align_mode_reg;
    logic [15:0]        line_height_reg;
    logic signed [23:0] anchor_y_reg;

    logic               cfg_wr;
    logic [2:0]         cfg_idx;

    logic               accept;
    logic               in_range;
    logic               is_char;
    logic               is_end;
    logic               is_close;
    logic               glyph_wr;
    glyph_t             wr_glyph;
    glyph_t             rd_glyph;
    glyph_t             space_glyph;
    logic               clearing;
    logic               s1_free;
    logic               close_valid;
    logic               close_ready;
    close_t             close;

    // Register file
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_x_reg     <= SCALE_RESET;
            scale_y_reg     <= SCALE_RESET;
            align_mode_reg  <= '0;
            line_height_reg <= '0;
            anchor_y_reg    <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_SCALE_X:     scale_x_reg     <= pwdata[15:0];
                REG_SCALE_Y:     scale_y_reg     <= pwdata[15:0];
                REG_ALIGN_MODE:  align_mode_reg  <= pwdata[3:0];
                REG_LINE_HEIGHT: line_height_reg <= pwdata[15:0];
                REG_ANCHOR_Y:    anchor_y_reg    <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_SCALE_X:     prdata = {16'b0, scale_x_reg};
            REG_SCALE_Y:     prdata = {16'b0, scale_y_reg};
            REG_ALIGN_MODE:  prdata = {28'b0, align_mode_reg};
            REG_LINE_HEIGHT: prdata = {16'b0, line_height_reg};
            REG_ANCHOR_Y:    prdata = {8'b0, anchor_y_reg};
            default:         prdata = '0;
        endcase
    end

    // Input decode
    assign s_ready  = !clearing && s1_free;
    assign accept   = s_valid && s_ready;
    assign in_range = ({1'b0, s_data.char_code} < 17'(CODE_SPACE));
    assign is_char  = (s_data.req_type == REQ_CHAR);
    assign is_end   = (s_data.req_type == REQ_END);
    assign is_close = is_end || (is_char && s_data.char_code == NEWLINE_CODE);
    assign glyph_wr = accept && (s_data.req_type == REQ_GLYPH) && in_range;

    assign wr_glyph.present = s_data.glyph_present;
    assign wr_glyph.advance = s_data.glyph_advance;

    tlma_glyph_ram #(
        .CODE_SPACE (CODE_SPACE)
    ) u_ram (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .wr_en       (glyph_wr),
        .wr_addr     (s_data.char_code[AW-1:0]),
        .wr_data     (wr_glyph),
        .rd_en       (accept && is_char),
        .rd_addr     (s_data.char_code[AW-1:0]),
        .rd_data     (rd_glyph),
        .space_glyph (space_glyph),
        .clearing    (clearing)
    );

    tlma_line_acc u_acc (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (accept && (is_char || is_end)),
        .load_close    (is_close),
        .load_last     (is_end),
        .load_in_range (in_range),
        .rd_glyph      (rd_glyph),
        .space_glyph   (space_glyph),
        .scale_x       (scale_x_reg),
        .line_height   (line_height_reg),
        .close_ready   (close_ready),
        .s1_free       (s1_free),
        .close_valid   (close_valid),
        .close         (close)
    );

    tlma_align_pipe u_align (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .close_valid (close_valid),
        .close       (close),
        .close_ready (close_ready),
        .scale_y     (scale_y_reg),
        .align_mode  (align_mode_reg),
        .anchor_y    (anchor_y_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

/* src/tlma_checker.sv */
`timescale 1ns / 1ps
module tlma_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input tlma_pkg::tlma_in_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input tlma_pkg::tlma_out_t m_data
);

    // A stalled result transfer holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Running maximum covers the current line and never goes negative
    a_max_width: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.total_width >= m_data.line_width) && !m_data.total_width[31])
        else $error("total width below line width");

    // Top y only on the end-of-text result
    a_top_y: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last |-> m_data.top_y == 32'sd0)
        else $error("top y set on a non-final line");

endmodule

bind text_line_measure_align_top tlma_checker u_tlma_checker (.*);

/* test/text_line_measure_checker.sv */
`timescale 1ns / 1ps
// Watches the APB port and both streams. It keeps its own copy of the glyph
// table, the line state and the registers, and predicts one result per
// closed line. Each m_ transfer is compared with the oldest prediction.
module text_line_measure_checker #(
    parameter int CODE_SPACE = 256
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  tlma_pkg::tlma_in_t             s_data,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  tlma_pkg::tlma_out_t            m_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [tlma_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output int                             lines_due,
    output int                             mismatches
);
    import tlma_pkg::*;

    // Glyph table copy
    logic               glyph_defined [CODE_SPACE];
    logic signed [15:0] glyph_adv_tbl [CODE_SPACE];

    // Per-text state
    logic signed [31:0] line_sum;
    logic signed [31:0] max_width;
    logic [23:0]        height_sum;

    // Register copy
    logic [15:0]        scale_x;
    logic [15:0]        scale_y;
    logic [3:0]         align_mode;
    logic [15:0]        line_height;
    logic signed [23:0] anchor_y;

    tlma_out_t expected_lines [$];
    int        lines_seen  = 0;
    int        fault_count = 0;
    int        due_count   = 0;

    assign lines_due  = due_count;
    assign mismatches = fault_count;

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns  mismatch: %s", $time, what);
        fault_count++;
    endtask

    // Update the copy for one accepted item, queue a result when a line closes
    task automatic measure_item(input tlma_in_t it);
        longint             step;
        longint             span;
        logic signed [31:0] w;
        logic [24:0]        hsum;
        halign_t            hsel;
        int                 vsel;
        tlma_out_t          line;
        case (it.req_type)
            REQ_GLYPH: begin
                // codes beyond the table are dropped
                if (it.char_code < CODE_SPACE) begin
                    glyph_defined[it.char_code] = it.glyph_present;
                    glyph_adv_tbl[it.char_code] = it.glyph_advance;
                end
            end
            REQ_CHAR, REQ_END: begin
                if (it.req_type == REQ_CHAR && it.char_code != NEWLINE_CODE) begin
                    // own glyph, else space, else the fixed fallback
                    if (it.char_code < CODE_SPACE && glyph_defined[it.char_code]) begin
                        step = glyph_adv_tbl[it.char_code];
                    end else if (glyph_defined[SPACE_CODE]) begin
                        step = glyph_adv_tbl[SPACE_CODE];
                    end else begin
                        step = MISSING_ADVANCE;
                    end
                    line_sum = clamp32(longint'(line_sum) + step);
                end else begin
                    w    = clamp32(longint'(line_sum) * longint'(scale_x));
                    hsel = halign_t'(align_mode % 3);
                    vsel = align_mode / 3;
                    line.line_width = w;
                    case (hsel)
                        HALIGN_CENTER: line.line_offset = clamp32(-longint'(w) >>> 1);
                        HALIGN_RIGHT:  line.line_offset = clamp32(-longint'(w));
                        default:       line.line_offset = '0;
                    endcase
                    if (w > max_width) begin
                        max_width = w;
                    end
                    hsum       = {1'b0, height_sum} + {9'd0, line_height};
                    height_sum = (hsum > HEIGHT_MAX) ? HEIGHT_MAX : hsum[23:0];
                    line_sum   = '0;
                    line.total_width  = max_width;
                    line.total_height = height_sum;
                    line.last         = (it.req_type == REQ_END);
                    line.top_y        = '0;
                    if (line.last) begin
                        // vertical selectors above bottom fall back to top
                        span = longint'(height_sum) * longint'(scale_y);
                        case (vsel)
                            VALIGN_MIDDLE: line.top_y = clamp32(longint'(anchor_y) - span / 2);
                            VALIGN_BOTTOM: line.top_y = clamp32(longint'(anchor_y) - span);
                            default:       line.top_y = clamp32(longint'(anchor_y));
                        endcase
                        max_width  = '0;
                        height_sum = '0;
                    end
                    expected_lines.insert(expected_lines.size(), line);
                end
            end
            default: ;
        endcase
    endtask

    // Compare one result transfer with the oldest prediction
    task automatic check_line(input tlma_out_t got);
        tlma_out_t want;
        lines_seen++;
        if (expected_lines.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing predicted", lines_seen));
        end else begin
            want = expected_lines.pop_front();
            if (got.line_offset !== want.line_offset)
                report_mismatch($sformatf("result %0d line_offset %0d, predicted %0d",
                                          lines_seen, got.line_offset, want.line_offset));
            if (got.line_width !== want.line_width)
                report_mismatch($sformatf("result %0d line_width %0d, predicted %0d",
                                          lines_seen, got.line_width, want.line_width));
            if (got.total_width !== want.total_width)
                report_mismatch($sformatf("result %0d total_width %0d, predicted %0d",
                                          lines_seen, got.total_width, want.total_width));
            if (got.total_height !== want.total_height)
                report_mismatch($sformatf("result %0d total_height %0d, predicted %0d",
                                          lines_seen, got.total_height, want.total_height));
            if (got.top_y !== want.top_y)
                report_mismatch($sformatf("result %0d top_y %0d, predicted %0d",
                                          lines_seen, got.top_y, want.top_y));
            if (got.last !== want.last)
                report_mismatch($sformatf("result %0d last %0b, predicted %0b",
                                          lines_seen, got.last, want.last));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CODE_SPACE; c++) begin
                glyph_defined[c] = 1'b0;
                glyph_adv_tbl[c] = '0;
            end
            line_sum    = '0;
            max_width   = '0;
            height_sum  = '0;
            scale_x     = SCALE_RESET;
            scale_y     = SCALE_RESET;
            align_mode  = '0;
            line_height = '0;
            anchor_y    = '0;
            expected_lines.delete();
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[CFG_ADDR_W-1:2])
                    REG_SCALE_X:     scale_x     = pwdata[15:0];
                    REG_SCALE_Y:     scale_y     = pwdata[15:0];
                    REG_ALIGN_MODE:  align_mode  = pwdata[3:0];
                    REG_LINE_HEIGHT: line_height = pwdata[15:0];
                    REG_ANCHOR_Y:    anchor_y    = pwdata[23:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                measure_item(s_data);
            end
            if (m_valid && m_ready) begin
                check_line(m_data);
            end
        end
        due_count <= expected_lines.size();
    end

endmodule

/* test/tb_text_line_measure_align_top.sv */
`timescale 1ns / 1ps
module tb_text_line_measure_align_top;
    import tlma_pkg::*;

    localparam int         GLYPH_CODES  = 256;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         LONG_HOLD    = 400;
    localparam logic [1:0] REQ_SPARE    = 2'd3;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    tlma_in_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    tlma_out_t             m_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    int lines_due;
    int mismatches;

    // sender pacing and receiver hold requests
    bit steady        = 1'b0;
    int burst_left    = 0;
    int hold_requests = 0;

    always #10 aclk = ~aclk;

    text_line_measure_align_top #(
        .CODE_SPACE(GLYPH_CODES)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    text_line_measure_checker #(
        .CODE_SPACE(GLYPH_CODES)
    ) line_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .lines_due  (lines_due),
        .mismatches (mismatches)
    );

    // One input transfer; bursts with random gaps unless steady is set
    task automatic offer(input logic [1:0] req, input logic [15:0] code,
                         input logic [15:0] adv, input logic present);
        int gap;
        if (!steady && burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        s_valid <= 1'b1;
        s_data  <= '{req_type: req, char_code: code, glyph_advance: adv,
                     glyph_present: present};
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop offering and wait for every predicted line, then for the pipe
    task automatic wait_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (lines_due != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // APB write: setup then access, then back to idle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_layout(input logic [15:0] sx, input logic [15:0] sy,
                              input logic [3:0] mode, input logic [15:0] lh,
                              input logic [23:0] ay);
        write_reg(REG_SCALE_X, {16'd0, sx});
        write_reg(REG_SCALE_Y, {16'd0, sy});
        write_reg(REG_ALIGN_MODE, {28'd0, mode});
        write_reg(REG_LINE_HEIGHT, {16'd0, lh});
        write_reg(REG_ANCHOR_Y, {{8{ay[23]}}, ay});
    endtask

    // Result side: phases of full rate, random and mostly stalled, plus long holds
    initial begin : result_sink
        int holds_done;
        int mode_left;
        int mode;
        holds_done = 0;
        mode_left  = 0;
        mode       = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (holds_done != hold_requests) begin
                holds_done++;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(1, 40);
            end
            mode_left--;
            case (mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    initial begin : stimulus
        int          phase;
        int          issued;
        int          pick;
        logic [15:0] sx;
        logic [15:0] sy;
        logic [15:0] lh;
        logic [23:0] ay;
        logic [15:0] code;
        logic [15:0] adv;
        logic [1:0]  req;
        logic        present;

        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset registers, empty table, fallbacks and table edges
        offer(REQ_CHAR, 16'd65, 16'h0000, 1'b0);          // nothing defined: fixed advance
        offer(REQ_CHAR, NEWLINE_CODE, 16'hFFFF, 1'b1);
        offer(REQ_GLYPH, SPACE_CODE, 16'd6, 1'b1);
        offer(REQ_GLYPH, 16'd255, 16'h7FFF, 1'b1);
        offer(REQ_GLYPH, 16'd0, 16'h8000, 1'b1);
        offer(REQ_GLYPH, 16'd256, 16'd100, 1'b1);         // beyond table, dropped
        offer(REQ_GLYPH, 16'hFFFF, 16'hFFFF, 1'b1);
        offer(REQ_CHAR, 16'd65, 16'd0, 1'b0);             // falls back to space
        offer(REQ_CHAR, 16'd256, 16'd0, 1'b0);
        offer(REQ_CHAR, 16'hFFFF, 16'hFFFF, 1'b1);
        offer(REQ_CHAR, 16'd255, 16'd0, 1'b0);
        offer(REQ_CHAR, 16'd255, 16'd0, 1'b0);
        offer(REQ_CHAR, NEWLINE_CODE, 16'd0, 1'b0);
        offer(REQ_CHAR, 16'd0, 16'd0, 1'b0);
        offer(REQ_END, 16'd0, 16'd0, 1'b0);
        offer(REQ_SPARE, 16'hFFFF, 16'hFFFF, 1'b1);       // unknown request
        offer(REQ_GLYPH, SPACE_CODE, 16'd7, 1'b0);        // space undefined again
        offer(REQ_CHAR, 16'd66, 16'd0, 1'b0);
        offer(REQ_END, 16'd0, 16'd0, 1'b0);
        offer(REQ_END, 16'd0, 16'd0, 1'b0);               // empty text

        // Directed: extreme registers, width and top y saturation
        wait_until_drained();
        set_layout(16'hFFFF, 16'hFFFF, 4'd8, 16'hFFFF, 24'h800000);
        offer(REQ_CHAR, 16'd255, 16'd0, 1'b0);
        offer(REQ_CHAR, 16'd255, 16'd0, 1'b0);
        offer(REQ_CHAR, NEWLINE_CODE, 16'd0, 1'b0);
        offer(REQ_CHAR, 16'd0, 16'd0, 1'b0);
        offer(REQ_CHAR, 16'd0, 16'd0, 1'b0);
        offer(REQ_END, 16'd0, 16'd0, 1'b0);

        // Random texts, one alignment mode per phase
        for (phase = 0; phase < 16; phase++) begin
            wait_until_drained();
            case (phase)
                1: begin
                    sx = 16'd0;
                    sy = 16'd0;
                    lh = 16'd0;
                    ay = 24'h7FFFFF;
                end
                2: begin
                    sx = 16'hFFFF;
                    sy = 16'hFFFF;
                    lh = 16'hFFFF;
                    ay = 24'h800000;
                end
                default: begin
                    sx = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(64, 768));
                    sy = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(64, 768));
                    lh = ($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 40));
                    ay = 24'($urandom());
                end
            endcase
            set_layout(sx, sy, 4'(phase), lh, ay);
            issued = 0;
            while (issued < 50) begin
                if (phase == 6 && issued == 20) begin
                    hold_requests++;
                end
                pick    = $urandom_range(0, 99);
                code    = $urandom_range(0, 1) ? 16'($urandom_range(32, 63))
                                               : 16'($urandom_range(0, 255));
                adv     = 16'($urandom());
                present = 1'($urandom());
                if (pick < 12) begin
                    req = REQ_GLYPH;
                    if ($urandom_range(0, 4) == 0) begin
                        code = SPACE_CODE;
                    end else if ($urandom_range(0, 9) == 0) begin
                        code = 16'($urandom());
                    end
                    present = ($urandom_range(0, 5) != 0);
                    if ($urandom_range(0, 3) != 0) begin
                        adv = 16'($urandom_range(0, 50)) - 16'd8;
                    end
                end else if (pick < 74) begin
                    req = REQ_CHAR;
                    if ($urandom_range(0, 9) == 0) begin
                        code = 16'($urandom());
                    end
                end else if (pick < 90) begin
                    req  = REQ_CHAR;
                    code = NEWLINE_CODE;
                end else if (pick < 97) begin
                    req = REQ_END;
                end else begin
                    req = REQ_SPARE;
                end
                offer(req, code, adv, present);
                if (req != REQ_SPARE) begin
                    issued++;
                end
            end
        end

        // Tall text under a long receiver hold: height saturates, input backs up
        wait_until_drained();
        set_layout(16'd256, 16'hFFFF, 4'd7, 16'hFFFF, 24'h000100);
        hold_requests++;
        steady = 1'b1;
        repeat (260) offer(REQ_CHAR, NEWLINE_CODE, 16'($urandom()), 1'($urandom()));
        offer(REQ_END, 16'($urandom()), 16'($urandom()), 1'($urandom()));

        // Lines of extreme advances, largest positive then largest negative
        wait_until_drained();
        set_layout(16'd1, 16'd256, 4'd2, 16'd1, 24'd0);
        offer(REQ_GLYPH, 16'd255, 16'h7FFF, 1'b1);
        offer(REQ_GLYPH, 16'd0, 16'h8000, 1'b1);
        repeat (16) offer(REQ_CHAR, 16'd255, 16'd0, 1'b0);
        offer(REQ_CHAR, NEWLINE_CODE, 16'd0, 1'b0);
        repeat (16) offer(REQ_CHAR, 16'd0, 16'd0, 1'b0);
        offer(REQ_END, 16'd0, 16'd0, 1'b0);
        steady = 1'b0;

        wait_until_drained();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Hard limit on run length
    initial begin : watchdog
        #3_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
src/tlma_pkg.sv
src/tlma_glyph_ram.sv
src/tlma_line_acc.sv
src/tlma_align_pipe.sv
src/text_line_measure_align_top.sv
src/tlma_checker.sv
test/text_line_measure_checker.sv
test/tb_text_line_measure_align_top.sv
